// ===== hw/rtl/ifa_pkg.sv =====
// Package for the integer to ASCII formatter: shared constants, the job
// record passed from the converter to the emitter, and the digit-to-character map.
// No dependencies.
package ifa_pkg;

  // Field widths.
  localparam int BIN_W    = 32;
  localparam int DIG_W    = 4;
  localparam int NUM_DIGS = 10;
  localparam int BCD_W    = NUM_DIGS * DIG_W;
  localparam int CHAR_W   = 8;
  localparam int LEN_W    = 4;

  // Mode codes. Bit 1 of the mode selects hexadecimal.
  localparam logic [1:0] MODE_SDEC = 2'd0;
  localparam logic [1:0] MODE_UDEC = 2'd1;
  localparam logic [1:0] MODE_HEX  = 2'd2;
  localparam int         MODE_HEX_BIT = 1;

  // Character codes.
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] DIGIT_TEN  = 8'd10;
  localparam logic [DIG_W-1:0]  DIGIT_NINE = 4'd9;

  // A finished conversion: ten digits, most significant in the top nibble.
  typedef struct packed {
    logic [BCD_W-1:0]  digits;
    logic              neg;
    logic [CHAR_W-1:0] letter;
  } job_t;

  // Maps one digit to its character; letters wrap modulo 256.
  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIG_W-1:0] d,
                                                    input logic [CHAR_W-1:0] letter);
    logic [CHAR_W-1:0] d_ext;
    d_ext = {{(CHAR_W-DIG_W){1'b0}}, d};
    if (d <= DIGIT_NINE) begin
      digit_char = CHAR_ZERO + d_ext;
    end else begin
      digit_char = letter + d_ext - DIGIT_TEN;
    end
  endfunction

endpackage

// ===== hw/rtl/ifa_if.sv =====
// Channel interfaces for the integer to ASCII formatter: input and result
// channels with valid/ready handshakes. Depends on ifa_pkg.
interface ifa_in_if;
  logic                        valid;
  logic                        ready;
  logic [ifa_pkg::BIN_W-1:0]   value;
  logic [1:0]                  mode;
  logic [ifa_pkg::CHAR_W-1:0]  letter_base;

  modport source (output valid, value, mode, letter_base, input ready);
  modport sink   (input valid, value, mode, letter_base, output ready);
endinterface

interface ifa_out_if;
  logic                        valid;
  logic                        ready;
  logic [ifa_pkg::CHAR_W-1:0]  char_code;
  logic [ifa_pkg::LEN_W-1:0]   total_length;
  logic                        is_last;

  modport source (output valid, char_code, total_length, is_last, input ready);
  modport sink   (input valid, char_code, total_length, is_last, output ready);
endinterface

// ===== hw/rtl/ifa_dabble.sv =====
// Binary to BCD converter: shift-add-3, one input bit per cycle. Hex values
// load their nibbles directly. Depends on ifa_pkg and ifa_in_if.
module ifa_dabble (
  input  logic           clk,
  input  logic           rst_n,
  ifa_in_if.sink         in_ch,
  output ifa_pkg::job_t  job,
  output logic           job_valid,
  input  logic           job_ready
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  localparam int STEP_W = $clog2(ifa_pkg::BIN_W);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(ifa_pkg::BIN_W - 1);

  logic [1:0]                    state_r, state_nxt;
  logic [ifa_pkg::BIN_W-1:0]     bin_r, bin_nxt;
  logic [ifa_pkg::BCD_W-1:0]     bcd_r, bcd_nxt;
  logic [STEP_W-1:0]             step_r, step_nxt;
  logic                          neg_r, neg_nxt;
  logic [ifa_pkg::CHAR_W-1:0]    letter_r, letter_nxt;

  logic                          accept;
  logic                          neg_in;
  logic [ifa_pkg::BIN_W-1:0]     mag;
  logic [ifa_pkg::BCD_W-1:0]     adj;

  // Add three to every digit of five or more before the shift.
  always_comb begin
    for (int i = 0; i < ifa_pkg::NUM_DIGS; i++) begin
      if (bcd_r[i*ifa_pkg::DIG_W +: ifa_pkg::DIG_W] >= 4'd5) begin
        adj[i*ifa_pkg::DIG_W +: ifa_pkg::DIG_W] =
          bcd_r[i*ifa_pkg::DIG_W +: ifa_pkg::DIG_W] + 4'd3;
      end else begin
        adj[i*ifa_pkg::DIG_W +: ifa_pkg::DIG_W] =
          bcd_r[i*ifa_pkg::DIG_W +: ifa_pkg::DIG_W];
      end
    end
  end

  // Input capture and sign handling.
  always_comb begin
    in_ch.ready = (state_r == ST_IDLE);
    accept      = in_ch.valid && in_ch.ready;
    neg_in      = (in_ch.mode == ifa_pkg::MODE_SDEC) && in_ch.value[ifa_pkg::BIN_W-1];
    mag         = neg_in ? (~in_ch.value + 32'd1) : in_ch.value;
  end

  // Sequencer for load, shift steps and handoff.
  always_comb begin
    state_nxt  = state_r;
    bin_nxt    = bin_r;
    bcd_nxt    = bcd_r;
    step_nxt   = step_r;
    neg_nxt    = neg_r;
    letter_nxt = letter_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          letter_nxt = in_ch.letter_base;
          neg_nxt    = neg_in;
          step_nxt   = '0;
          if (in_ch.mode[ifa_pkg::MODE_HEX_BIT]) begin
            bcd_nxt   = {{(ifa_pkg::BCD_W-ifa_pkg::BIN_W){1'b0}}, in_ch.value};
            state_nxt = ST_DONE;
          end else begin
            bin_nxt   = mag;
            bcd_nxt   = '0;
            state_nxt = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        bcd_nxt  = {adj[ifa_pkg::BCD_W-2:0], bin_r[ifa_pkg::BIN_W-1]};
        bin_nxt  = {bin_r[ifa_pkg::BIN_W-2:0], 1'b0};
        step_nxt = step_r + 1'b1;
        if (step_r == LAST_STEP) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (job_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bin_r    <= bin_nxt;
    bcd_r    <= bcd_nxt;
    neg_r    <= neg_nxt;
    letter_r <= letter_nxt;
  end

  // Finished digits go to the emitter.
  assign job_valid   = (state_r == ST_DONE);
  assign job.digits  = bcd_r;
  assign job.neg     = neg_r;
  assign job.letter  = letter_r;

endmodule

// ===== hw/rtl/ifa_emit.sv =====
// Character emitter: skips leading zero digits one per cycle, then sends
// the sign and one digit character per transaction. Depends on ifa_pkg, ifa_out_if.
module ifa_emit (
  input  logic           clk,
  input  logic           rst_n,
  input  ifa_pkg::job_t  job,
  input  logic           job_valid,
  output logic           job_ready,
  ifa_out_if.source      out_ch
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  localparam int DW = ifa_pkg::DIG_W;
  localparam int BW = ifa_pkg::BCD_W;
  localparam logic [ifa_pkg::LEN_W-1:0] FULL_CNT = ifa_pkg::LEN_W'(ifa_pkg::NUM_DIGS);
  localparam logic [ifa_pkg::LEN_W-1:0] ONE_CNT  = ifa_pkg::LEN_W'(1);

  logic [1:0]                    state_r, state_nxt;
  logic [BW-1:0]                 dig_r, dig_nxt;
  logic [ifa_pkg::LEN_W-1:0]     cnt_r, cnt_nxt;
  logic [ifa_pkg::LEN_W-1:0]     total_r, total_nxt;
  logic                          neg_r, neg_nxt;
  logic                          minus_r, minus_nxt;
  logic [ifa_pkg::CHAR_W-1:0]    letter_r, letter_nxt;

  logic                          ovalid_r, ovalid_nxt;
  logic [ifa_pkg::CHAR_W-1:0]    ochar_r, ochar_nxt;
  logic [ifa_pkg::LEN_W-1:0]     olen_r, olen_nxt;
  logic                          olast_r, olast_nxt;

  logic                          slot_free;

  assign job_ready = (state_r == ST_IDLE);
  assign slot_free = !ovalid_r || out_ch.ready;

  always_comb begin
    state_nxt  = state_r;
    dig_nxt    = dig_r;
    cnt_nxt    = cnt_r;
    total_nxt  = total_r;
    neg_nxt    = neg_r;
    minus_nxt  = minus_r;
    letter_nxt = letter_r;
    ovalid_nxt = ovalid_r && !out_ch.ready;
    ochar_nxt  = ochar_r;
    olen_nxt   = olen_r;
    olast_nxt  = olast_r;
    case (state_r)
      ST_IDLE: begin
        if (job_valid) begin
          dig_nxt    = job.digits;
          neg_nxt    = job.neg;
          letter_nxt = job.letter;
          cnt_nxt    = FULL_CNT;
          state_nxt  = ST_SCAN;
        end
      end
      // Drop one leading zero digit per cycle, keeping at least one digit.
      ST_SCAN: begin
        if ((cnt_r > ONE_CNT) && (dig_r[BW-1 -: DW] == '0)) begin
          dig_nxt = {dig_r[BW-DW-1:0], {DW{1'b0}}};
          cnt_nxt = cnt_r - 1'b1;
        end else begin
          total_nxt = cnt_r + {{(ifa_pkg::LEN_W-1){1'b0}}, neg_r};
          minus_nxt = neg_r;
          state_nxt = ST_EMIT;
        end
      end
      // Load one character into the output register when it is free.
      ST_EMIT: begin
        if (slot_free) begin
          ovalid_nxt = 1'b1;
          olen_nxt   = total_r;
          if (minus_r) begin
            ochar_nxt = ifa_pkg::CHAR_MINUS;
            olast_nxt = 1'b0;
            minus_nxt = 1'b0;
          end else begin
            ochar_nxt = ifa_pkg::digit_char(dig_r[BW-1 -: DW], letter_r);
            olast_nxt = (cnt_r == ONE_CNT);
            dig_nxt   = {dig_r[BW-DW-1:0], {DW{1'b0}}};
            cnt_nxt   = cnt_r - 1'b1;
            if (cnt_r == ONE_CNT) begin
              state_nxt = ST_IDLE;
            end
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      ovalid_r <= 1'b0;
      minus_r  <= 1'b0;
      cnt_r    <= '0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
      minus_r  <= minus_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dig_r    <= dig_nxt;
    total_r  <= total_nxt;
    neg_r    <= neg_nxt;
    letter_r <= letter_nxt;
    ochar_r  <= ochar_nxt;
    olen_r   <= olen_nxt;
    olast_r  <= olast_nxt;
  end

  assign out_ch.valid        = ovalid_r;
  assign out_ch.char_code    = ochar_r;
  assign out_ch.total_length = olen_r;
  assign out_ch.is_last      = olast_r;

endmodule

// ===== hw/rtl/integer_to_ascii_formatter_unit.sv =====
// Integer to ASCII formatter, top level. Depends on ifa_pkg, ifa_if, ifa_dabble, ifa_emit.
// Decimal values pass through 32 shift-add-3 steps in the converter, then the emitter drops each
// leading zero digit before the first character; hex values skip the shift steps.
// Throughput: one character per cycle while out_ch.ready holds; the converter takes the next
// value while the emitter still sends.
// Reset (synchronous, active low) clears the sequencers and the output valid; no data is kept.
module integer_to_ascii_formatter_unit (
  input  logic       clk,
  input  logic       rst_n,
  ifa_in_if.sink     in_ch,
  ifa_out_if.source  out_ch
);

  ifa_pkg::job_t job;
  logic          job_valid;
  logic          job_ready;

  // Binary to digit conversion.
  ifa_dabble u_dabble (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .job       (job),
    .job_valid (job_valid),
    .job_ready (job_ready)
  );

  // Leading zero skip and character output.
  ifa_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .job       (job),
    .job_valid (job_valid),
    .job_ready (job_ready),
    .out_ch    (out_ch)
  );

endmodule

// ===== dv/integer_to_ascii_formatter_unit_test.sv =====
// Self-checking testbench for integer_to_ascii_formatter_unit: drives values, predicts
// the character stream of each conversion and checks every result transaction in order.
// Depends on ifa_pkg, ifa_if and the formatter RTL.
`timescale 1ns / 100ps

module integer_to_ascii_formatter_unit_test;

  localparam int         HALF_PERIOD   = 5;
  localparam int         RESET_CYCLES  = 5;
  localparam int         RANDOM_ITEMS  = 350;
  localparam int         MAX_IDLE      = 19;
  localparam int         HOLD_CYCLES   = 800;
  localparam int         DRAIN_CYCLES  = 60;
  localparam int         IDLE_LIMIT    = 4000;
  localparam int         HOLD_AT_ITEM  = 100;
  localparam int         PAUSE_AT_ITEM = 220;
  localparam logic [1:0] MODE_HEX_ALT  = 2'd3;
  localparam logic [7:0] LETTER_LOWER  = 8'h61;
  localparam logic [7:0] LETTER_UPPER  = 8'h41;

  // One expected character of a conversion.
  typedef struct {
    logic [ifa_pkg::CHAR_W-1:0] code;
    logic [ifa_pkg::LEN_W-1:0]  length;
    logic                       is_last;
  } char_rec_t;

  // Holds the characters still owed by the block and checks each one as it arrives.
  class char_ledger;
    char_rec_t expected_chars[$];
    int        mismatches;

    function new();
      mismatches = 0;
    endfunction

    function int pending();
      return expected_chars.size();
    endfunction

    task report_mismatch(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      mismatches++;
    endtask

    // Works out the characters of one accepted value and queues them.
    function void note_value(logic [ifa_pkg::BIN_W-1:0] value, logic [1:0] mode,
                             logic [ifa_pkg::CHAR_W-1:0] letter);
      logic [ifa_pkg::BIN_W-1:0]  mag;
      logic [ifa_pkg::BIN_W-1:0]  radix;
      logic [ifa_pkg::DIG_W-1:0]  digit;
      logic [ifa_pkg::CHAR_W-1:0] rev_chars[ifa_pkg::NUM_DIGS];
      logic                       negative;
      int                         ndig;
      int                         total;
      char_rec_t                  rec;
      mag      = value;
      radix    = 32'd10;
      negative = 1'b0;
      ndig     = 0;
      if (mode[ifa_pkg::MODE_HEX_BIT]) begin
        radix = 32'd16;
      end else if (mode == ifa_pkg::MODE_SDEC && value[ifa_pkg::BIN_W-1]) begin
        negative = 1'b1;
        mag      = ~value + 32'd1;
      end
      // Peel digits off the low end; the top digit ends up last.
      do begin
        digit = ifa_pkg::DIG_W'(mag % radix);
        if (digit <= 4'd9) begin
          rev_chars[ndig] = ifa_pkg::CHAR_ZERO + {4'd0, digit};
        end else begin
          rev_chars[ndig] = letter + {4'd0, digit} - 8'd10;
        end
        ndig++;
        mag = mag / radix;
      end while (mag != 0 && ndig < ifa_pkg::NUM_DIGS);
      total = ndig + int'(negative);
      if (negative) begin
        rec.code    = ifa_pkg::CHAR_MINUS;
        rec.length  = ifa_pkg::LEN_W'(total);
        rec.is_last = (total == 1);
        expected_chars.push_back(rec);
      end
      for (int i = ndig - 1; i >= 0; i--) begin
        rec.code    = rev_chars[i];
        rec.length  = ifa_pkg::LEN_W'(total);
        rec.is_last = (i == 0);
        expected_chars.push_back(rec);
      end
    endfunction

    // Compares one result transaction with the oldest expected character.
    task check_char(logic [ifa_pkg::CHAR_W-1:0] code, logic [ifa_pkg::LEN_W-1:0] length,
                    logic is_last);
      char_rec_t exp_rec;
      if (expected_chars.size() == 0) begin
        report_mismatch($sformatf("unexpected character 0x%02h", code));
      end else begin
        exp_rec = expected_chars.pop_front();
        if (code !== exp_rec.code)
          report_mismatch($sformatf("char_code 0x%02h, expected 0x%02h", code, exp_rec.code));
        if (length !== exp_rec.length)
          report_mismatch($sformatf("total_length %0d, expected %0d", length,
                                    exp_rec.length));
        if (is_last !== exp_rec.is_last)
          report_mismatch($sformatf("is_last %0b, expected %0b", is_last, exp_rec.is_last));
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n;

  ifa_in_if  in_ch();
  ifa_out_if out_ch();

  integer_to_ascii_formatter_unit i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  char_ledger ledger = new();

  bit hold_request = 1'b0;
  bit sink_holding = 1'b0;
  int send_burst   = 0;

  always #HALF_PERIOD clk = ~clk;

  // Offers one value, after a random gap outside bursts and sink hold-offs, and waits for its transaction.
  task automatic send_value(input logic [ifa_pkg::BIN_W-1:0] value, input logic [1:0] mode,
                            input logic [ifa_pkg::CHAR_W-1:0] letter);
    int gap;
    if (sink_holding || send_burst > 0) begin
      gap = 0;
      if (send_burst > 0) send_burst--;
    end else if ($urandom_range(0, 7) == 0) begin
      gap        = 0;
      send_burst = $urandom_range(5, 20);
    end else begin
      gap = $urandom_range(0, MAX_IDLE);
    end
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.value       <= value;
    in_ch.mode        <= mode;
    in_ch.letter_base <= letter;
    do @(posedge clk); while (!in_ch.ready);
    ledger.note_value(value, mode, letter);
  endtask

  // Withdraws the offer and waits until every expected character has arrived.
  task automatic wait_for_drain();
    in_ch.valid <= 1'b0;
    while (ledger.pending() != 0) @(posedge clk);
  endtask

  // Values biased toward digit-count boundaries, the sign edge and small numbers.
  function automatic logic [ifa_pkg::BIN_W-1:0] random_value();
    logic [ifa_pkg::BIN_W-1:0] power;
    int                        exp10;
    power = 32'd1;
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 20);
      1: begin
        exp10 = $urandom_range(1, 9);
        repeat (exp10) power = power * 32'd10;
        return power + $urandom_range(0, 2) - 32'd1;
      end
      2: return 32'd0 - $urandom_range(1, 20);
      3: return 32'd1 << $urandom_range(0, ifa_pkg::BIN_W - 1);
      4: return 32'h8000_0000 + $urandom_range(0, 3) - 32'd1;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [1:0] random_mode();
    case ($urandom_range(0, 3))
      0: return ifa_pkg::MODE_SDEC;
      1: return ifa_pkg::MODE_UDEC;
      2: return ifa_pkg::MODE_HEX;
      default: return MODE_HEX_ALT;
    endcase
  endfunction

  function automatic logic [ifa_pkg::CHAR_W-1:0] random_letter();
    case ($urandom_range(0, 3))
      0: return LETTER_LOWER;
      1: return LETTER_UPPER;
      default: return $urandom_range(0, 255);
    endcase
  endfunction

  // Result side: random stalls, bursts of steady ready, and one long hold-off.
  initial begin : result_sink
    int stall;
    int sink_burst;
    sink_burst = 0;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        sink_holding = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        sink_holding = 1'b0;
      end
      if (sink_burst > 0) begin
        stall = 0;
        sink_burst--;
      end else if ($urandom_range(0, 7) == 0) begin
        stall      = 0;
        sink_burst = $urandom_range(10, 40);
      end else begin
        stall = $urandom_range(0, MAX_IDLE);
      end
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  // Every result transaction goes to the ledger.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      ledger.check_char(out_ch.char_code, out_ch.total_length, out_ch.is_last);
  end

  // Ends the run if no transaction moves on either channel for too long.
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : stimulus
    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.value       <= '0;
    in_ch.mode        <= ifa_pkg::MODE_SDEC;
    in_ch.letter_base <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: zero, all ones, the most negative value, digit boundaries,
    // the unused mode and letters that wrap past 255.
    send_value(32'd0,          ifa_pkg::MODE_SDEC, LETTER_LOWER);
    send_value(32'd0,          ifa_pkg::MODE_UDEC, LETTER_LOWER);
    send_value(32'd0,          ifa_pkg::MODE_HEX,  LETTER_LOWER);
    send_value(32'hFFFF_FFFF,  ifa_pkg::MODE_SDEC, LETTER_LOWER);
    send_value(32'hFFFF_FFFF,  ifa_pkg::MODE_UDEC, LETTER_LOWER);
    send_value(32'hFFFF_FFFF,  ifa_pkg::MODE_HEX,  LETTER_LOWER);
    send_value(32'h8000_0000,  ifa_pkg::MODE_SDEC, LETTER_UPPER);
    send_value(32'h8000_0000,  ifa_pkg::MODE_UDEC, LETTER_UPPER);
    send_value(32'h8000_0000,  ifa_pkg::MODE_HEX,  LETTER_UPPER);
    send_value(32'h7FFF_FFFF,  ifa_pkg::MODE_SDEC, LETTER_UPPER);
    send_value(32'd9,          ifa_pkg::MODE_UDEC, LETTER_LOWER);
    send_value(32'd10,         ifa_pkg::MODE_UDEC, LETTER_LOWER);
    send_value(32'd1,          ifa_pkg::MODE_SDEC, LETTER_LOWER);
    send_value(32'd999999999,  ifa_pkg::MODE_UDEC, LETTER_LOWER);
    send_value(32'd1000000000, ifa_pkg::MODE_SDEC, LETTER_LOWER);
    send_value(32'hABCD_EF01,  MODE_HEX_ALT,       LETTER_UPPER);
    send_value(32'hFAFA_FAFA,  ifa_pkg::MODE_HEX,  8'hFF);
    send_value(32'h0000_000F,  ifa_pkg::MODE_HEX,  8'hFA);
    send_value(32'h1234_5678,  ifa_pkg::MODE_HEX,  8'h00);
    send_value(32'hFFFF_FFFF,  MODE_HEX_ALT,       8'hFC);
    send_value(32'h0000_0010,  MODE_HEX_ALT,       8'h80);
    wait_for_drain();

    // Random part, with a long result hold-off and a full drain part way through.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == HOLD_AT_ITEM) hold_request = 1'b1;
      if (n == PAUSE_AT_ITEM) wait_for_drain();
      send_value(random_value(), random_mode(), random_letter());
    end

    wait_for_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (ledger.mismatches == 0 && ledger.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/ifa_pkg.sv
hw/rtl/ifa_if.sv
hw/rtl/ifa_dabble.sv
hw/rtl/ifa_emit.sv
hw/rtl/integer_to_ascii_formatter_unit.sv
dv/integer_to_ascii_formatter_unit_test.sv
